### sv/set_assoc_table_with_age_replacement_core_defines.svh
// Assertion macros used by the checker file.
`ifndef SET_ASSOC_TABLE_WITH_AGE_REPLACEMENT_CORE_DEFINES_SVH
`define SET_ASSOC_TABLE_WITH_AGE_REPLACEMENT_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define SATAR_ASSERT_NOW(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define SATAR_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### sv/satar_pkg.sv
// Types, codes and entry helpers for the set-associative result table.
package satar_pkg;

	localparam logic [1:0] KIND_PROBE = 2'd0;
	localparam logic [1:0] KIND_SAVE  = 2'd1;
	localparam logic [1:0] KIND_OCC   = 2'd2;
	localparam logic [1:0] KIND_CLEAR = 2'd3;

	localparam logic CFG_GENERATION   = 1'b0;
	localparam logic CFG_DEPTH_OFFSET = 1'b1;

	localparam int          TAG_LSB      = 48;
	localparam logic [1:0]  EXACT_BOUND  = 2'd3;
	localparam int          PERMILLE     = 1000;
	localparam logic [7:0]  GEN_MASK     = 8'hF8;
	localparam logic [7:0]  AGE_BASE     = 8'd7;   // 263 mod 256
	localparam logic signed [11:0] DEPTH_SLACK = 12'sd4;
	localparam logic [7:0]  OFFSET_RESET = 8'hF9;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_MOD, ST_READ, ST_UPDATE, ST_SCAN, ST_DIV, ST_FIN
	} state_t;

	typedef struct packed {
		logic [15:0] tag;
		logic [15:0] move;
		logic [15:0] score;
		logic [15:0] eval;
		logic [7:0]  age;    // gen[7:3], pv[2], bound[1:0]
		logic [7:0]  depth;  // 0 = empty
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic        hit;
		logic [1:0]  slot_way;
		logic [15:0] score;
		logic [15:0] eval;
		logic [15:0] move;
		logic [7:0]  depth;
		logic        pv;
		logic [1:0]  bound;
		logic [9:0]  permille;
	} res_t;

	// replacement metric: depth minus relative age
	function automatic logic signed [9:0] worth(entry_t e, logic [4:0] gen);
		logic [7:0] rel;
		rel = (AGE_BASE + {gen, 3'b000} - e.age) & GEN_MASK;
		return $signed({2'b00, e.depth}) - $signed({2'b00, rel});
	endfunction

	function automatic entry_t save_entry(entry_t old, logic [15:0] tag,
		logic [15:0] move, logic [15:0] score, logic [15:0] eval,
		logic signed [8:0] depth, logic pv, logic [1:0] bound,
		logic [4:0] gen, logic signed [7:0] off);
		entry_t e;
		logic signed [10:0] sd;
		logic signed [11:0] lhs;
		logic signed [11:0] rhs;
		logic tdiff;
		e = old;
		sd = {{2{depth[8]}}, depth} - {{3{off[7]}}, off};
		lhs = {sd[10], sd} + $signed({10'd0, pv, 1'b0});
		rhs = $signed({4'd0, old.depth}) - DEPTH_SLACK;
		tdiff = old.tag != tag;
		if (move != 16'd0 || tdiff) e.move = move;
		if (bound == EXACT_BOUND || tdiff || lhs > rhs) begin
			e.tag = tag;
			e.score = score;
			e.eval = eval;
			e.age = {gen, pv, bound};
			e.depth = sd[7:0];
		end
		return e;
	endfunction

endpackage

### sv/satar_req_if.sv
// Request channel: one operation per beat.
interface satar_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [63:0]        key;
	logic [1:0]         target_way;
	logic signed [15:0] score;
	logic signed [15:0] static_eval;
	logic [15:0]        best_move;
	logic signed [8:0]  search_depth;
	logic               pv_flag;
	logic [1:0]         bound_kind;

	modport source(output valid, kind, key, target_way, score, static_eval, best_move,
		search_depth, pv_flag, bound_kind, input ready);
	modport sink(input valid, kind, key, target_way, score, static_eval, best_move,
		search_depth, pv_flag, bound_kind, output ready);
endinterface

### sv/satar_rsp_if.sv
// Response channel: one result beat per operation.
interface satar_rsp_if;
	logic               valid;
	logic               ready;
	logic               hit;
	logic [1:0]         slot_way;
	logic signed [15:0] stored_score;
	logic signed [15:0] stored_eval;
	logic [15:0]        stored_move;
	logic [7:0]         stored_depth;
	logic               stored_pv;
	logic [1:0]         stored_bound;
	logic [9:0]         occupancy_permille;

	modport source(output valid, hit, slot_way, stored_score, stored_eval, stored_move,
		stored_depth, stored_pv, stored_bound, occupancy_permille, input ready);
	modport sink(input valid, hit, slot_way, stored_score, stored_eval, stored_move,
		stored_depth, stored_pv, stored_bound, occupancy_permille, output ready);
endinterface

### sv/satar_cfg_if.sv
// Configuration write channel.
interface satar_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [7:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### sv/set_assoc_table_with_age_replacement_core.sv
// Top level of the set-associative result table with depth/age replacement.
// Channels: req (operation beats), rsp (one result beat per operation),
// cfg (register writes, always ready; generation at index 0, depth offset at 1).
// One operation is in flight at a time; req is ready only while the control
// sequencer is idle, and a finished result sits in the rsp register while the
// next request is taken.
// Each cluster is one row of a single RAM (WAYS entries of 80 bits).
// Probe/save: accept, index, row read, modify and write back, result. The index
//   is a mask when CLUSTER_COUNT is a power of two, else a reciprocal remainder
//   over 16-bit key chunks.
// Occupancy: streams min(CLUSTER_COUNT, SAMPLE_CLUSTERS) rows, then a
//   reciprocal divide.
// Clear: one row written per cycle.
// Reset: the same clearing pass runs with req.ready held low;
//   cfg writes are still taken.
// A stalled rsp holds its beat; the sequencer waits with a new result until
// the rsp register is free.
module set_assoc_table_with_age_replacement_core
	import satar_pkg::*;
#(
	parameter int CLUSTER_COUNT   = 4096,
	parameter int WAYS            = 3,
	parameter int SAMPLE_CLUSTERS = 1000
) (
	input logic         clk,
	input logic         arst_n,
	satar_req_if.sink   req,
	satar_rsp_if.source rsp,
	satar_cfg_if.sink   cfg
);
	localparam int IW     = (CLUSTER_COUNT > 1) ? $clog2(CLUSTER_COUNT) : 1;
	localparam int ROWS_S = (CLUSTER_COUNT < SAMPLE_CLUSTERS) ? CLUSTER_COUNT
		: SAMPLE_CLUSTERS;
	localparam int TOTAL  = ROWS_S * WAYS;
	localparam int SW     = $clog2(ROWS_S + 1);
	localparam int CW     = $clog2(TOTAL + 1);
	localparam int RW     = WAYS * ENTRY_W;

	state_t state_q, state_d;

	logic [4:0]        gen_q;
	logic signed [7:0] off_q;

	logic [1:0]         kind_q;
	logic [15:0]        tag_q;
	logic [1:0]         way_q;
	logic [15:0]        score_q;
	logic [15:0]        eval_q;
	logic [15:0]        move_q;
	logic signed [8:0]  depth_q;
	logic               pv_q;
	logic [1:0]         bound_q;
	logic [IW-1:0]      idx_q;
	logic [IW-1:0]      clr_q;
	logic               clr_resp_q;
	logic [SW-1:0]      scan_q;
	logic [CW-1:0]      cnt_q;
	logic               rd_vld_s1;
	res_t               res_q;
	res_t               out_q;
	logic               out_valid_q;

	logic acc;
	logic clr_last;
	logic scan_done;
	logic out_free;

	logic          ram_we, ram_re;
	logic [IW-1:0] ram_waddr, ram_raddr;
	logic [RW-1:0] ram_wdata, ram_rdata;

	entry_t [WAYS-1:0] row_rd;
	entry_t [WAYS-1:0] row_new;
	entry_t            sel;
	logic              upd_we;
	logic              found;
	logic              hit;
	logic [1:0]        pick;
	logic signed [9:0] best;
	logic [2:0]        row_cnt;

	logic          mod_start, mod_done;
	logic [IW-1:0] mod_rem;
	logic          div_start, div_done;
	logic [9:0]    div_quo;

	assign acc = req.valid && req.ready;
	assign req.ready = state_q == ST_IDLE;
	assign cfg.ready = 1'b1;
	assign clr_last = clr_q == IW'(CLUSTER_COUNT - 1);
	assign scan_done = scan_q == SW'(ROWS_S);
	assign out_free = !out_valid_q || rsp.ready;
	assign row_rd = ram_rdata;

	assign mod_start = acc && (req.kind == KIND_PROBE || req.kind == KIND_SAVE);
	assign div_start = state_q == ST_SCAN && state_d == ST_DIV;

	satar_ram #(.WIDTH(RW), .DEPTH(CLUSTER_COUNT)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
	);

	satar_mod #(.CLUSTER_COUNT(CLUSTER_COUNT)) u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start), .key(req.key),
		.done(mod_done), .rem(mod_rem)
	);

	satar_div #(.TOTAL(TOTAL)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .cnt(cnt_q),
		.done(div_done), .quo(div_quo)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (clr_last) state_d = clr_resp_q ? ST_FIN : ST_IDLE;
			ST_IDLE: begin
				if (acc) begin
					case (req.kind)
						KIND_PROBE, KIND_SAVE: state_d = ST_MOD;
						KIND_OCC:              state_d = ST_SCAN;
						KIND_CLEAR:            state_d = ST_CLEAR;
						default:               state_d = ST_IDLE;
					endcase
				end
			end
			ST_MOD:    if (mod_done) state_d = ST_READ;
			ST_READ:   state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_FIN;
			ST_SCAN:   if (scan_done && !rd_vld_s1) state_d = ST_DIV;
			ST_DIV:    if (div_done) state_d = ST_FIN;
			ST_FIN:    if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// RAM port controls
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = row_new;
		ram_re = 1'b0;
		ram_raddr = idx_q;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_READ:   ram_re = 1'b1;
			ST_UPDATE: ram_we = upd_we;
			ST_SCAN: begin
				ram_re = !scan_done;
				ram_raddr = IW'(scan_q);
			end
			default: ram_re = 1'b0;
		endcase
	end

	// probe / save modify of the cluster row
	always_comb begin
		row_new = row_rd;
		sel = '0;
		upd_we = 1'b0;
		found = 1'b0;
		hit = 1'b0;
		pick = '0;
		best = '0;
		if (kind_q == KIND_PROBE) begin
			for (int w = 0; w < WAYS; w++) begin
				if (!found) begin
					if (row_rd[w].depth != 8'd0 && row_rd[w].tag == tag_q) begin
						found = 1'b1;
						hit = 1'b1;
						pick = 2'(w);
						row_new[w].age = {gen_q, row_rd[w].age[2:0]};
						upd_we = 1'b1;
					end else if (row_rd[w].depth == 8'd0) begin
						found = 1'b1;
						pick = 2'(w);
					end
				end
			end
			if (!found) begin
				// lowest way wins ties
				best = worth(row_rd[0], gen_q);
				for (int w = 1; w < WAYS; w++) begin
					if (best > worth(row_rd[w], gen_q)) begin
						best = worth(row_rd[w], gen_q);
						pick = 2'(w);
					end
				end
			end
			for (int w = 0; w < WAYS; w++)
				if (2'(w) == pick) sel = row_new[w];
		end else begin
			pick = way_q;
			for (int w = 0; w < WAYS; w++) begin
				if (2'(w) == way_q) begin
					row_new[w] = save_entry(row_rd[w], tag_q, move_q, score_q, eval_q,
						depth_q, pv_q, bound_q, gen_q, off_q);
					upd_we = 1'b1;
					sel = row_new[w];
				end
			end
		end
	end

	always_comb begin
		row_cnt = '0;
		for (int w = 0; w < WAYS; w++)
			if (row_rd[w].depth != 8'd0 && row_rd[w].age[7:3] == gen_q)
				row_cnt = row_cnt + 3'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			gen_q <= '0;
			off_q <= OFFSET_RESET;
			clr_q <= '0;
			clr_resp_q <= 1'b0;
			scan_q <= '0;
			cnt_q <= '0;
			rd_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				case (cfg.index)
					CFG_GENERATION:   gen_q <= cfg.data[4:0];
					CFG_DEPTH_OFFSET: off_q <= cfg.data;
					default:          gen_q <= gen_q;
				endcase
			end
			if (state_q == ST_CLEAR) clr_q <= clr_last ? '0 : clr_q + IW'(1);
			rd_vld_s1 <= ram_re && state_q == ST_SCAN;
			if (acc) begin
				clr_resp_q <= req.kind == KIND_CLEAR;
				scan_q <= '0;
				cnt_q <= '0;
			end else begin
				if (state_q == ST_SCAN && !scan_done) scan_q <= scan_q + SW'(1);
				if (rd_vld_s1) cnt_q <= cnt_q + CW'(row_cnt);
			end
			if (state_q == ST_FIN && out_free) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			kind_q <= req.kind;
			tag_q <= req.key[63:TAG_LSB];
			way_q <= req.target_way;
			score_q <= req.score;
			eval_q <= req.static_eval;
			move_q <= req.best_move;
			depth_q <= req.search_depth;
			pv_q <= req.pv_flag;
			bound_q <= req.bound_kind;
			res_q <= '0;
		end
		if (state_q == ST_MOD && mod_done) idx_q <= mod_rem;
		if (state_q == ST_UPDATE) begin
			res_q.hit <= hit;
			res_q.slot_way <= pick;
			res_q.score <= sel.score;
			res_q.eval <= sel.eval;
			res_q.move <= sel.move;
			res_q.depth <= sel.depth;
			res_q.pv <= sel.age[2];
			res_q.bound <= sel.age[1:0];
		end
		if (state_q == ST_DIV && div_done) res_q.permille <= div_quo;
		if (state_q == ST_FIN && out_free) out_q <= res_q;
	end

	assign rsp.valid = out_valid_q;
	assign rsp.hit = out_q.hit;
	assign rsp.slot_way = out_q.slot_way;
	assign rsp.stored_score = out_q.score;
	assign rsp.stored_eval = out_q.eval;
	assign rsp.stored_move = out_q.move;
	assign rsp.stored_depth = out_q.depth;
	assign rsp.stored_pv = out_q.pv;
	assign rsp.stored_bound = out_q.bound;
	assign rsp.occupancy_permille = out_q.permille;
endmodule

### sv/satar_ram.sv
// Generic single-write, single-read RAM with registered read data.
module satar_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule

### sv/satar_mod.sv
// Key to cluster index: mask for power-of-two counts, else a reciprocal remainder.
module satar_mod
	import satar_pkg::*;
#(
	parameter int CLUSTER_COUNT = 4096,
	localparam int IW = (CLUSTER_COUNT > 1) ? $clog2(CLUSTER_COUNT) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [63:0]   key,
	output logic          done,
	output logic [IW-1:0] rem
);
	localparam bit IS_POW2 = (CLUSTER_COUNT & (CLUSTER_COUNT - 1)) == 0;

	generate
		if (IS_POW2) begin : g_mask
			logic          done_q;
			logic [IW-1:0] rem_q;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) done_q <= 1'b0;
				else done_q <= start;
			end
			always_ff @(posedge clk) begin
				if (start) rem_q <= (CLUSTER_COUNT == 1) ? '0 : key[IW-1:0];
			end
			assign done = done_q;
			assign rem = rem_q;
		end else begin : g_recip
			// exact floor(t / CLUSTER_COUNT) for any 32-bit t
			localparam int LG = $clog2(CLUSTER_COUNT);
			localparam int SH = 32 + LG;
			localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(CLUSTER_COUNT) - 64'd1)
				/ 64'(CLUSTER_COUNT);

			logic          busy_q;
			logic          done_q;
			logic          ph_q;
			logic [1:0]    cnt_q;
			logic [63:0]   key_q;
			logic [IW-1:0] r_q;
			logic [31:0]   t_s1;
			logic [31:0]   q_s1;
			logic [31:0]   t;
			logic [64:0]   prod;
			logic [31:0]   qc;

			// Horner over 16-bit key chunks, msb first: quotient, then remainder
			always_comb begin
				t = {16'(r_q), key_q[63:48]};
				prod = 65'(t) * 65'(RECIP[32:0]);
				qc = q_s1 * 32'(CLUSTER_COUNT);
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					done_q <= 1'b0;
					ph_q <= 1'b0;
					cnt_q <= '0;
				end else begin
					done_q <= 1'b0;
					if (start) begin
						busy_q <= 1'b1;
						ph_q <= 1'b0;
						cnt_q <= '0;
					end else if (busy_q) begin
						ph_q <= !ph_q;
						if (ph_q) begin
							cnt_q <= cnt_q + 2'd1;
							if (cnt_q == 2'd3) begin
								busy_q <= 1'b0;
								done_q <= 1'b1;
							end
						end
					end
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					key_q <= key;
					r_q <= '0;
				end else if (busy_q) begin
					if (!ph_q) begin
						t_s1 <= t;
						q_s1 <= 32'(prod >> SH);
						key_q <= {key_q[47:0], 16'd0};
					end else begin
						r_q <= IW'(t_s1 - qc);
					end
				end
			end
			assign done = done_q;
			assign rem = r_q;
		end
	endgenerate
endmodule

### sv/satar_div.sv
// Permille of a count over a fixed entry total, by reciprocal multiplication.
module satar_div
	import satar_pkg::*;
#(
	parameter int TOTAL = 3000,
	localparam int CW = $clog2(TOTAL + 1),
	localparam int DW = CW + 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [CW-1:0] cnt,
	output logic          done,
	output logic [9:0]    quo
);
	// exact floor(x / TOTAL) for any DW-bit x
	localparam int SH = DW + $clog2(TOTAL);
	localparam int MW = DW + 1;
	localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(TOTAL) - 64'd1) / 64'(TOTAL);

	logic             vld_s1;
	logic             done_q;
	logic [DW-1:0]    num_s1;
	logic [9:0]       quo_q;
	logic [DW+MW-1:0] prod;

	assign prod = (DW+MW)'(num_s1) * (DW+MW)'(RECIP[MW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) num_s1 <= DW'(cnt) * DW'(PERMILLE);
		if (vld_s1) quo_q <= 10'(prod >> SH);
	end

	assign done = done_q;
	assign quo = quo_q;
endmodule

### sv/satar_chk.sv
// Port-level checker for the result table, bound to the top level.
`include "set_assoc_table_with_age_replacement_core_defines.svh"

module satar_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       rsp_hit,
	input logic [9:0] rsp_occ
);
	`SATAR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp beat dropped")
	`SATAR_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "second request taken")
	`SATAR_ASSERT_NOW(a_permille_range, rsp_valid, rsp_occ <= 10'd1000, "permille out of range")
	`SATAR_ASSERT_NOW(a_hit_not_occ, rsp_valid && rsp_occ != 10'd0, !rsp_hit, "hit on occupancy")
endmodule

bind set_assoc_table_with_age_replacement_core satar_chk u_chk (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_hit(rsp.hit), .rsp_occ(rsp.occupancy_permille)
);

### tb/set_assoc_table_with_age_replacement_core_tb.sv
// Testbench for the set-associative result table: directed, config sweep and random traffic.
module set_assoc_table_with_age_replacement_core_tb;
	import satar_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLUSTERS  = 4096;
	localparam int NWAYS     = 3;
	localparam int SAMPLED   = 1000;
	localparam int NSLOTS    = CLUSTERS * NWAYS;
	localparam int CYCLE_CAP = 30000000;

	typedef struct {
		logic [1:0]         kind;
		logic [63:0]        key;
		logic [1:0]         way;
		logic signed [15:0] score;
		logic signed [15:0] eval;
		logic [15:0]        move;
		logic signed [8:0]  depth;
		logic               pv;
		logic [1:0]         bound;
	} op_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	satar_req_if req();
	satar_rsp_if rsp();
	satar_cfg_if cfg();

	set_assoc_table_with_age_replacement_core uut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg)
	);

	always #2 clk = ~clk;

	// shadow of the table and its registers
	entry_t             slots [NSLOTS];
	logic [4:0]         cur_gen = 5'd0;
	logic signed [7:0]  cur_offset = -8'sd7;
	logic [1:0]         probe_way = 2'd0;
	res_t               result_q [$];
	int                 errors = 0;
	int                 cycles = 0;
	bit                 quiet = 1'b0;
	logic [11:0]        cluster_pool [8];
	logic [15:0]        tag_pool [6];

	function automatic int age_worth(entry_t e, logic [4:0] g);
		int rel;
		rel = (263 + int'({g, 3'b000}) - int'(e.age)) & 248;
		return int'(e.depth) - rel;
	endfunction

	function automatic res_t slot_view(res_t r, entry_t e);
		r.score = e.score;
		r.eval  = e.eval;
		r.move  = e.move;
		r.depth = e.depth;
		r.pv    = e.age[2];
		r.bound = e.age[1:0];
		return r;
	endfunction

	function automatic res_t predict_table(op_t o);
		res_t r;
		entry_t e;
		logic [15:0] tg;
		int base, i, pick, sd, pvv, cnt;
		bit found;
		r = '0;
		tg = o.key[63:48];
		base = int'(o.key[11:0]) * NWAYS;
		found = 1'b0;
		case (o.kind)
			KIND_PROBE: begin
				for (int w = 0; w < NWAYS; w++) begin
					i = base + w;
					if (slots[i].depth != 0 && slots[i].tag == tg) begin
						slots[i].age = {cur_gen, slots[i].age[2:0]};
						r.hit = 1'b1;
					end
					if (slots[i].depth == 0 || r.hit) begin
						r.slot_way = w[1:0];
						r = slot_view(r, slots[i]);
						found = 1'b1;
						break;
					end
				end
				if (!found) begin
					pick = 0;
					for (int w = 1; w < NWAYS; w++)
						if (age_worth(slots[base + pick], cur_gen) > age_worth(slots[base + w], cur_gen))
							pick = w;
					r.slot_way = pick[1:0];
					r = slot_view(r, slots[base + pick]);
				end
				probe_way = r.slot_way;
			end
			KIND_SAVE: begin
				r.slot_way = o.way;
				if (o.way < NWAYS) begin
					i = base + int'(o.way);
					e = slots[i];
					sd = int'(o.depth) - int'(cur_offset);
					pvv = o.pv ? 1 : 0;
					if (o.move != 16'd0 || e.tag != tg)
						e.move = o.move;
					if (o.bound == EXACT_BOUND || e.tag != tg || sd + 2 * pvv > int'(e.depth) - 4) begin
						e.tag   = tg;
						e.score = o.score;
						e.eval  = o.eval;
						e.age   = {cur_gen, o.pv, o.bound};
						e.depth = sd[7:0];
					end
					slots[i] = e;
					r = slot_view(r, e);
				end
			end
			KIND_OCC: begin
				cnt = 0;
				for (int k = 0; k < SAMPLED * NWAYS; k++)
					if (slots[k].depth != 0 && (slots[k].age & GEN_MASK) == {cur_gen, 3'b000})
						cnt++;
				r.permille = 10'(cnt * PERMILLE / (SAMPLED * NWAYS));
			end
			default: foreach (slots[k]) slots[k] = '0;
		endcase
		return r;
	endfunction

	function automatic op_t mk_op(logic [1:0] kind, logic [63:0] key, logic [1:0] way,
		logic signed [15:0] score, logic signed [15:0] eval, logic [15:0] move,
		logic signed [8:0] depth, logic pv, logic [1:0] bound);
		op_t o;
		o.kind = kind; o.key = key; o.way = way; o.score = score; o.eval = eval;
		o.move = move; o.depth = depth; o.pv = pv; o.bound = bound;
		return o;
	endfunction

	function automatic logic [63:0] pick_key(bit near);
		logic [63:0] k;
		k = {$urandom, $urandom};
		if (near) begin
			k[11:0]  = cluster_pool[$urandom_range(0, 7)];
			k[63:48] = tag_pool[$urandom_range(0, 5)];
		end
		return k;
	endfunction

	function automatic op_t random_save(logic [63:0] key, logic [1:0] way);
		logic signed [8:0] d;
		if ($urandom_range(0, 4) != 0)
			d = 9'($urandom_range(1, 40));
		else
			d = 9'(int'($urandom_range(0, 383)) - 128);
		return mk_op(KIND_SAVE, key, way, 16'($urandom), 16'($urandom),
			($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom), d,
			1'($urandom), 2'($urandom));
	endfunction

	task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
		$display("mismatch %s: expected %0h got %0h at cycle %0d", what, want, got, cycles);
		errors++;
	endtask

	task automatic send_op(op_t o);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			@(negedge clk) req.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req.valid <= 1'b1;
		req.kind <= o.kind;
		req.key <= o.key;
		req.target_way <= o.way;
		req.score <= o.score;
		req.static_eval <= o.eval;
		req.best_move <= o.move;
		req.search_depth <= o.depth;
		req.pv_flag <= o.pv;
		req.bound_kind <= o.bound;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		result_q.push_back(predict_table(o));
	endtask

	task automatic drain();
		@(negedge clk) req.valid <= 1'b0;
		while (result_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic cfg_write(logic idx, logic [7:0] data);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		if (idx == CFG_GENERATION)
			cur_gen = data[4:0];
		else
			cur_offset = data;
		@(negedge clk) cfg.valid <= 1'b0;
	endtask

	task automatic refill_pools();
		foreach (cluster_pool[k])
			cluster_pool[k] = (k < 5) ? 12'($urandom_range(0, SAMPLED - 1)) : 12'($urandom);
		foreach (tag_pool[k])
			tag_pool[k] = 16'($urandom);
	endtask

	// extremes, hit/miss/victim, ignored way, wrap to empty, occupancy, clear
	task automatic test_directed();
		logic [63:0] a, b, c, d;
		a = 64'hFFFF_0000_0000_0FFF;
		b = 64'h0000_FFFF_FFFF_FFFF;
		c = 64'h8000_1234_5678_9FFF;
		d = 64'h7FFF_0000_0000_0FFF;
		send_op(mk_op(KIND_PROBE, a, 2'd0, 0, 0, 0, 0, 0, 0));
		send_op(mk_op(KIND_SAVE, a, 2'd0, 16'sh7FFF, -16'sd32768, 16'hFFFF, 9'sd255, 1'b1, 2'd3));
		send_op(mk_op(KIND_PROBE, a, 2'd0, 0, 0, 0, 0, 0, 0));
		send_op(mk_op(KIND_SAVE, a, 2'd0, -16'sd1, 16'sd1, 16'd0, 9'sd1, 1'b0, 2'd1));
		send_op(mk_op(KIND_SAVE, a, 2'd0, -16'sd32768, 16'sh7FFF, 16'd0, -9'sd128, 1'b0, 2'd0));
		send_op(mk_op(KIND_SAVE, b, 2'd3, 16'sd5, 16'sd5, 16'd9, 9'sd10, 1'b1, 2'd2));
		send_op(mk_op(KIND_SAVE, c, 2'd1, 16'sd3, 16'sd4, 16'd7, 9'sd20, 1'b0, 2'd2));
		send_op(mk_op(KIND_SAVE, d, 2'd2, 16'sd6, 16'sd8, 16'd0, 9'sd2, 1'b1, 2'd1));
		send_op(mk_op(KIND_PROBE, b, 2'd0, 0, 0, 0, 0, 0, 0));
		// depth of offset+256 wraps to an empty entry
		send_op(mk_op(KIND_SAVE, b, 2'd0, 16'sd1, 16'sd1, 16'd1, 9'sd249, 1'b0, 2'd3));
		send_op(mk_op(KIND_PROBE, b, 2'd0, 0, 0, 0, 0, 0, 0));
		send_op(mk_op(KIND_SAVE, b, 2'd0, 16'sd2, 16'sd2, 16'd0, 9'sd30, 1'b0, 2'd0));
		send_op(mk_op(KIND_PROBE, 64'h1111_0000_0000_0FFF, 2'd0, 0, 0, 0, 0, 0, 0));
		send_op(mk_op(KIND_OCC, 64'd0, 2'd0, 0, 0, 0, 0, 0, 0));
		send_op(mk_op(KIND_CLEAR, 64'd0, 2'd0, 0, 0, 0, 0, 0, 0));
		send_op(mk_op(KIND_PROBE, a, 2'd0, 0, 0, 0, 0, 0, 0));
		send_op(mk_op(KIND_OCC, 64'd0, 2'd0, 0, 0, 0, 0, 0, 0));
		drain();
	endtask

	// generation at 31 then 0, depth offset at its minimum then 0, with traffic against aged entries
	task automatic test_config_sweep();
		logic [63:0] k;
		k = 64'hABCD_0000_0000_0010;
		cfg_write(CFG_GENERATION, 8'd31);
		cfg_write(CFG_DEPTH_OFFSET, 8'h80);
		send_op(mk_op(KIND_SAVE, k, 2'd1, 16'sd9, 16'sd9, 16'd3, 9'sd255, 1'b1, 2'd2));
		send_op(mk_op(KIND_PROBE, k, 2'd0, 0, 0, 0, 0, 0, 0));
		send_op(mk_op(KIND_OCC, 64'd0, 2'd0, 0, 0, 0, 0, 0, 0));
		drain();
		cfg_write(CFG_GENERATION, 8'd0);
		cfg_write(CFG_DEPTH_OFFSET, 8'h00);
		send_op(mk_op(KIND_PROBE, k, 2'd0, 0, 0, 0, 0, 0, 0));
		send_op(mk_op(KIND_SAVE, k, 2'd1, 16'sd1, 16'sd1, 16'd0, -9'sd128, 1'b0, 2'd1));
		send_op(mk_op(KIND_OCC, 64'd0, 2'd0, 0, 0, 0, 0, 0, 0));
		drain();
	endtask

	// phases of probe/save pairs with random noise; registers change between phases
	task automatic test_random(int total);
		int sent, roll, phase;
		logic [63:0] k;
		sent = 0;
		phase = 0;
		while (sent < total) begin
			refill_pools();
			cfg_write(CFG_GENERATION, 8'($urandom_range(0, 31)));
			cfg_write(CFG_DEPTH_OFFSET, 8'(-int'($urandom_range(0, 128))));
			quiet = (phase % 4 == 2);
			for (int n = 0; n < 200 && sent < total; n++) begin
				if (phase == 3 && n < 20)
					drain();
				roll = $urandom_range(0, 999);
				k = pick_key($urandom_range(0, 9) != 0);
				if (roll < 600) begin
					send_op(mk_op(KIND_PROBE, k, 2'd0, 0, 0, 0, 0, 0, 0));
					if (roll < 30)
						k = pick_key(1'b1);
					send_op(random_save(k, probe_way));
					sent += 2;
				end else if (roll < 800) begin
					send_op(mk_op(KIND_PROBE, k, 2'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom), 9'($urandom), 1'($urandom), 2'($urandom)));
					sent++;
				end else if (roll < 975) begin
					send_op(random_save(k, 2'($urandom)));
					sent++;
				end else if (roll < 996) begin
					send_op(mk_op(KIND_OCC, {$urandom, $urandom}, 0, 0, 0, 0, 0, 0, 0));
					sent++;
				end else begin
					send_op(mk_op(KIND_CLEAR, {$urandom, $urandom}, 0, 0, 0, 0, 0, 0, 0));
					sent++;
				end
			end
			drain();
			phase++;
		end
		quiet = 1'b0;
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("set_assoc_table_with_age_replacement_core_tb: FAIL");
			$finish;
		end
	end

	// result beats
	always @(posedge clk) begin
		res_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (result_q.size() == 0) begin
				report_mismatch("unexpected beat", 0, 1);
			end else begin
				want = result_q.pop_front();
				if (rsp.hit !== want.hit) report_mismatch("hit", want.hit, rsp.hit);
				if (rsp.slot_way !== want.slot_way)
					report_mismatch("slot_way", want.slot_way, rsp.slot_way);
				if (rsp.stored_score !== want.score)
					report_mismatch("stored_score", want.score, rsp.stored_score);
				if (rsp.stored_eval !== want.eval)
					report_mismatch("stored_eval", want.eval, rsp.stored_eval);
				if (rsp.stored_move !== want.move)
					report_mismatch("stored_move", want.move, rsp.stored_move);
				if (rsp.stored_depth !== want.depth)
					report_mismatch("stored_depth", want.depth, rsp.stored_depth);
				if (rsp.stored_pv !== want.pv) report_mismatch("stored_pv", want.pv, rsp.stored_pv);
				if (rsp.stored_bound !== want.bound)
					report_mismatch("stored_bound", want.bound, rsp.stored_bound);
				if (rsp.occupancy_permille !== want.permille)
					report_mismatch("occupancy_permille", want.permille, rsp.occupancy_permille);
			end
		end
	end

	// receiver stalls
	initial begin
		int n;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = quiet ? 0 : $urandom_range(0, 8);
			if (n > 0) begin
				@(negedge clk) rsp.ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end
			@(negedge clk) rsp.ready <= 1'b1;
			@(posedge clk);
			while (!rsp.valid) @(posedge clk);
		end
	end

	initial begin
		req.valid = 1'b0;
		req.kind = KIND_PROBE;
		req.key = '0;
		req.target_way = '0;
		req.score = '0;
		req.static_eval = '0;
		req.best_move = '0;
		req.search_depth = '0;
		req.pv_flag = 1'b0;
		req.bound_kind = '0;
		cfg.valid = 1'b0;
		cfg.index = CFG_GENERATION;
		cfg.data = '0;
		foreach (slots[k]) slots[k] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		test_directed();
		test_config_sweep();
		test_random(1700);
		drain();
		if (errors == 0)
			$display("set_assoc_table_with_age_replacement_core_tb: PASS");
		else
			$display("set_assoc_table_with_age_replacement_core_tb: FAIL");
		$finish;
	end

endmodule
